// ===== rtl/core/stq_pkg.sv =====
// sorted timer queue package: payload structs, op/kind/status codes,
// controller-to-datapath command and status structs; no dependencies
`default_nettype none
package stq_pkg;
  localparam int unsigned TableDepth = 16;
  localparam int unsigned MaxOut = 16;
  localparam logic [9:0] TickStepReset = 10'd10;

  localparam logic [1:0] OpAdd = 2'd0;
  localparam logic [1:0] OpDel = 2'd1;
  localparam logic [1:0] OpPend = 2'd2;
  localparam logic [1:0] OpTick = 2'd3;

  localparam logic [2:0] KindAdd = 3'd0;
  localparam logic [2:0] KindDel = 3'd1;
  localparam logic [2:0] KindPend = 3'd2;
  localparam logic [2:0] KindExp = 3'd3;
  localparam logic [2:0] KindNone = 3'd4;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] expiry_time;
    logic [15:0] query_id;
    logic [31:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  status;
    logic [15:0] timer_id;
    logic [31:0] timer_handle;
    logic        is_pending;
    logic        head_changed;
    logic        last;
  } out_item_t;

  // controller commands to the datapath
  typedef struct packed {
    logic load;       // capture input item
    logic add_time;   // current_time += step
    logic do_add;     // insert captured item
    logic do_del;     // delete first id match
    logic pop_head;   // remove head entry
  } cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic        full;
    logic        empty;
    logic        id_hit;
    logic        head_due;
    logic        next_due;
    logic        ins_head;
    logic [15:0] next_id;
    logic [15:0] head_id;
    logic [31:0] head_handle;
    logic [15:0] qid;
    logic [1:0]  op;
  } stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/stq_datapath.sv =====
// sorted timer queue datapath: shifting sorted slot table, time and id counters
// depends on stq_pkg
`default_nettype none
module stq_datapath #(
  parameter int unsigned Depth = stq_pkg::TableDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire stq_pkg::cmd_t  cmd_i,
  input  wire stq_pkg::in_item_t item_i,
  input  wire logic [9:0]     step_i,
  output stq_pkg::stat_t      stat_o
);
  import stq_pkg::*;

  logic [Depth-1:0]  valid_q, valid_d;
  logic [31:0]       exp_q [Depth];
  logic [15:0]       id_q [Depth];
  logic [31:0]       hdl_q [Depth];
  logic [31:0]       time_q;
  logic [15:0]       nid_q;
  in_item_t          it_q;

  logic [Depth-1:0]  lt;     // entry sorts before the new one
  logic [Depth-1:0]  hit;    // id match
  logic [Depth-1:0]  first_hit;
  logic [Depth-1:0]  at_or_after; // at or after the first hit

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      lt[i] = valid_q[i] && (exp_q[i] < it_q.expiry_time);
      hit[i] = valid_q[i] && (id_q[i] == it_q.query_id);
    end
    at_or_after[0] = hit[0];
    for (int i = 1; i < Depth; i++) at_or_after[i] = at_or_after[i-1] | hit[i];
    first_hit = at_or_after & ~(at_or_after << 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      time_q <= '0;
      nid_q <= '0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.add_time) time_q <= time_q + {22'd0, step_i};
      if (cmd_i.do_add && !valid_q[Depth-1]) nid_q <= nid_q + 16'd1;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.do_add && !valid_q[Depth-1]) valid_d = {valid_q[Depth-2:0], 1'b1};
    else if ((cmd_i.do_del && (|hit)) || (cmd_i.pop_head && valid_q[0]))
      valid_d = valid_q >> 1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= item_i;
    for (int i = 0; i < Depth; i++) begin
      if (cmd_i.do_add && !valid_q[Depth-1]) begin
        if (!lt[i]) begin
          if (i == 0 || lt[i-1]) begin
            exp_q[i] <= it_q.expiry_time;
            id_q[i] <= nid_q;
            hdl_q[i] <= it_q.handle;
          end else if (i > 0) begin
            exp_q[i] <= exp_q[i-1];
            id_q[i] <= id_q[i-1];
            hdl_q[i] <= hdl_q[i-1];
          end
        end
      end else if ((cmd_i.do_del && at_or_after[i]) || cmd_i.pop_head) begin
        if (i + 1 < Depth) begin
          exp_q[i] <= exp_q[i+1];
          id_q[i] <= id_q[i+1];
          hdl_q[i] <= hdl_q[i+1];
        end
      end
    end
  end

  assign stat_o.full = valid_q[Depth-1];
  assign stat_o.empty = !valid_q[0];
  assign stat_o.id_hit = |first_hit;
  assign stat_o.head_due = valid_q[0] && (exp_q[0] <= time_q);
  assign stat_o.next_due = valid_q[1] && (exp_q[1] <= time_q);
  assign stat_o.ins_head = !lt[0];
  assign stat_o.next_id = nid_q;
  assign stat_o.head_id = id_q[0];
  assign stat_o.head_handle = hdl_q[0];
  assign stat_o.qid = it_q.query_id;
  assign stat_o.op = it_q.operation;
endmodule
`default_nettype wire

// ===== rtl/core/stq_ctrl.sv =====
// sorted timer queue controller: sequences one item, forms result items
// depends on stq_pkg
`default_nettype none
module stq_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output stq_pkg::out_item_t   out_data_o,
  output stq_pkg::cmd_t        cmd_o,
  input  wire stq_pkg::stat_t  stat_i
);
  import stq_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SExec = 2'd1;
  localparam logic [1:0] STick = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        ov_q, ov_d;
  out_item_t   od_q, od_d;
  logic        free;

  assign free = !ov_q || !out_stall_i;
  assign in_stall_o = (state_q != SIdle);
  assign out_valid_o = ov_q;
  assign out_data_o = od_q;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    ov_d = ov_q && out_stall_i;
    od_d = od_q;
    cmd_o = '0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = SExec;
        end
      end
      SExec: begin
        if (free) begin
          ov_d = 1'b1;
          od_d = '0;
          od_d.last = 1'b1;
          od_d.timer_id = stat_i.qid;
          state_d = SIdle;
          case (stat_i.op)
            OpAdd: begin
              od_d.kind = KindAdd;
              if (stat_i.full) begin
                od_d.status = StFull;
                od_d.timer_id = '0;
              end else begin
                od_d.timer_id = stat_i.next_id;
                od_d.head_changed = stat_i.ins_head;
              end
              cmd_o.do_add = 1'b1;
            end
            OpDel: begin
              od_d.kind = KindDel;
              od_d.status = stat_i.empty ? StEmpty : (stat_i.id_hit ? StOk : StNotFound);
              cmd_o.do_del = 1'b1;
            end
            OpPend: begin
              od_d.kind = KindPend;
              od_d.is_pending = stat_i.id_hit;
            end
            default: begin
              ov_d = ov_q && out_stall_i;
              od_d = od_q;
              cmd_o.add_time = 1'b1;
              cnt_d = '0;
              state_d = STick;
            end
          endcase
        end
      end
      STick: begin
        // one expired timer per unstalled cycle; entry behind head and MaxOut set last
        if (free) begin
          ov_d = 1'b1;
          od_d = '0;
          if (stat_i.head_due) begin
            od_d.kind = KindExp;
            od_d.timer_id = stat_i.head_id;
            od_d.timer_handle = stat_i.head_handle;
            cmd_o.pop_head = 1'b1;
            cnt_d = cnt_q + 5'd1;
            if (stat_i.next_due && (cnt_q + 5'd1 < 5'(MaxOut))) begin
              state_d = STick;
            end else begin
              od_d.last = 1'b1;
              state_d = SIdle;
            end
          end else begin
            od_d.kind = KindNone;
            od_d.last = 1'b1;
            state_d = SIdle;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
  end
endmodule
`default_nettype wire

// ===== rtl/core/sorted_timer_queue.sv =====
// sorted timer queue top level: APB register, controller and datapath
// depends on stq_pkg, stq_ctrl, stq_datapath
`default_nettype none
// Keeps up to Depth timers sorted by expiry in a shifting table. Add, delete
// and pending are captured, then update the table with the result going into
// the output register; a tick is captured, advances the time, then removes one
// expired timer per cycle while the output is not stalled, up to 16 per tick,
// or gives a single none result when nothing expires. Output stalls hold the
// table update and pop steps. Results wait in an output register; a new item
// is taken once the last result of the previous one is registered.
module sorted_timer_queue #(
  parameter int unsigned Depth = stq_pkg::TableDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire stq_pkg::in_item_t   in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output stq_pkg::out_item_t       out_data_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [1:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import stq_pkg::*;

  logic [9:0] step_q;
  cmd_t       cmd;
  stat_t      stat;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {22'd0, step_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) step_q <= TickStepReset;
    else if (psel && penable && pwrite && paddr == 2'd0) step_q <= pwdata[9:0];
  end

  stq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .out_data_o, .cmd_o(cmd), .stat_i(stat)
  );

  stq_datapath #(.Depth(Depth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .item_i(in_data_i), .step_i(step_q), .stat_o(stat)
  );
endmodule
`default_nettype wire

// ===== verif/tb_sorted_timer_queue.sv =====
// testbench for sorted_timer_queue: directed and random items, predicted
// against a behavioral copy of the timer table; depends on stq_pkg and the rtl
`default_nettype none
module tb_sorted_timer_queue;
  import stq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sorted_timer_queue dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // timer table mirror
  logic [31:0] tbl_expiry [TableDepth];
  logic [15:0] tbl_id [TableDepth];
  logic [31:0] tbl_handle [TableDepth];
  int unsigned tbl_count;
  logic [31:0] now_time;
  logic [15:0] id_counter;
  logic [9:0] step_size;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int errors = 0;
  int accepted_cnt = 0;
  int driven_cnt = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  bit hold_sender = 1'b0;
  bit drv_free;

  function automatic out_item_t mk(logic [2:0] k, logic [1:0] s, logic [15:0] id,
                                   logic [31:0] h, logic p, logic hc);
    out_item_t r;
    r = '{kind: k, status: s, timer_id: id, timer_handle: h, is_pending: p,
          head_changed: hc, last: 1'b0};
    return r;
  endfunction

  task automatic drop_entry(int unsigned pos);
    for (int unsigned i = pos; i + 1 < tbl_count; i++) begin
      tbl_expiry[i] = tbl_expiry[i+1];
      tbl_id[i] = tbl_id[i+1];
      tbl_handle[i] = tbl_handle[i+1];
    end
    tbl_count--;
  endtask

  task automatic predict_timer_op(in_item_t it);
    out_item_t res[$];
    int unsigned pos;
    logic [1:0] st;
    logic hit;
    case (it.operation)
      OpAdd: begin
        if (tbl_count >= TableDepth) begin
          res.push_back(mk(KindAdd, StFull, '0, '0, 1'b0, 1'b0));
        end else begin
          pos = 0;
          while (pos < tbl_count && tbl_expiry[pos] < it.expiry_time) pos++;
          for (int unsigned i = tbl_count; i > pos; i--) begin
            tbl_expiry[i] = tbl_expiry[i-1];
            tbl_id[i] = tbl_id[i-1];
            tbl_handle[i] = tbl_handle[i-1];
          end
          tbl_expiry[pos] = it.expiry_time;
          tbl_id[pos] = id_counter;
          tbl_handle[pos] = it.handle;
          tbl_count++;
          res.push_back(mk(KindAdd, StOk, id_counter, '0, 1'b0, pos == 0));
          id_counter++;
        end
      end
      OpDel: begin
        st = StNotFound;
        if (tbl_count == 0) st = StEmpty;
        else begin
          for (int unsigned i = 0; i < tbl_count; i++)
            if (tbl_id[i] == it.query_id) begin
              drop_entry(i);
              st = StOk;
              break;
            end
        end
        res.push_back(mk(KindDel, st, it.query_id, '0, 1'b0, 1'b0));
      end
      OpPend: begin
        hit = 1'b0;
        for (int unsigned i = 0; i < tbl_count; i++)
          if (tbl_id[i] == it.query_id) hit = 1'b1;
        res.push_back(mk(KindPend, StOk, it.query_id, '0, hit, 1'b0));
      end
      default: begin
        now_time += 32'(step_size);
        while (res.size() < MaxOut && tbl_count > 0 && tbl_expiry[0] <= now_time) begin
          res.push_back(mk(KindExp, StOk, tbl_id[0], tbl_handle[0], 1'b0, 1'b0));
          drop_entry(0);
        end
        if (res.size() == 0) res.push_back(mk(KindNone, StOk, '0, '0, 1'b0, 1'b0));
      end
    endcase
    res[res.size()-1].last = 1'b1;
    foreach (res[i]) expected_results.push_back(res[i]);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      // the item on the bus is done once the monitor has counted it
      drv_free = !in_valid_i || (accepted_cnt == driven_cnt);
      if (drv_free) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0 && !hold_sender) begin
          in_data_i <= pending_items.pop_front();
          in_valid_i <= 1'b1;
          driven_cnt++;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(12, 0);
            gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(5, 0);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      // receiver stall pattern: phases of light, heavy and no stalling
      case ((accepted_cnt / 40) % 3)
        0: out_stall_i <= ($urandom_range(3, 0) == 0);
        1: out_stall_i <= ($urandom_range(3, 0) != 0);
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (in_valid_i && !in_stall_o) begin
        predict_timer_op(in_data_i);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $realtime, out_data_o);
          errors++;
        end else if (out_data_o !== expected_results[0]) begin
          $display("%0t: mismatch expected %p actual %p", $realtime,
                   expected_results[0], out_data_o);
          errors++;
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
      if (idle_cycles > 5000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic apb_write(logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    step_size = value[9:0];
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic in_item_t mk_op(logic [1:0] op, logic [31:0] e,
                                     logic [15:0] q, logic [31:0] h);
    in_item_t it;
    it = '{operation: op, expiry_time: e, query_id: q, handle: h};
    return it;
  endfunction

  // mostly ids that exist, plus random ones
  function automatic logic [15:0] pick_id();
    if (tbl_count > 0 && $urandom_range(3, 0) != 0)
      return tbl_id[$urandom_range(tbl_count - 1, 0)];
    return 16'($urandom());
  endfunction

  task automatic random_phase(int n);
    in_item_t it;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(9, 0);
      if (r < 4)
        it = mk_op(OpAdd, ($urandom_range(7, 0) == 0) ? $urandom() :
                   now_time + $urandom_range(300, 0), 16'($urandom()), $urandom());
      else if (r < 6) it = mk_op(OpDel, $urandom(), 16'($urandom()), $urandom());
      else if (r < 7) it = mk_op(OpPend, $urandom(), 16'($urandom()), $urandom());
      else it = mk_op(OpTick, $urandom(), 16'($urandom()), $urandom());
      // ids are taken from the mirror when the item is queued; wait so it stays current
      if (it.operation inside {OpDel, OpPend}) begin
        wait_drained();
        it.query_id = pick_id();
      end
      pending_items.push_back(it);
    end
  endtask

  initial begin
    tbl_count = 0;
    now_time = '0;
    id_counter = '0;
    step_size = TickStepReset;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty ops, extremes, fill past full, mass expiry
    pending_items.push_back(mk_op(OpDel, '0, 16'hffff, '0));
    pending_items.push_back(mk_op(OpPend, '0, '0, '0));
    pending_items.push_back(mk_op(OpTick, '0, '0, '0));
    pending_items.push_back(mk_op(OpAdd, 32'hffffffff, '0, 32'hffffffff));
    pending_items.push_back(mk_op(OpAdd, 32'd0, 16'hffff, 32'h0));
    for (int i = 0; i < 15; i++)
      pending_items.push_back(mk_op(OpAdd, 32'd5, 16'(i), 32'h1000 + i));
    pending_items.push_back(mk_op(OpPend, '0, 16'd1, '0));
    pending_items.push_back(mk_op(OpDel, '0, 16'd1, '0));
    pending_items.push_back(mk_op(OpDel, '0, 16'd1, '0));
    pending_items.push_back(mk_op(OpTick, '0, '0, '0));
    pending_items.push_back(mk_op(OpTick, '0, '0, '0));
    wait_drained();

    apb_write(32'd1023);
    random_phase(70);
    // sender holds off once the block has drained
    wait_drained();
    hold_sender = 1'b1;
    repeat (20) @(posedge clk_i);
    hold_sender = 1'b0;
    apb_write(32'd1);
    random_phase(70);
    wait_drained();
    apb_write(32'd0);
    pending_items.push_back(mk_op(OpTick, '0, '0, '0));
    random_phase(20);
    wait_drained();
    apb_write(32'd700);
    random_phase(70);
    wait_drained();
    apb_write(32'h3ff);
    for (int i = 0; i < 12; i++)
      pending_items.push_back(mk_op(OpTick, '0, '0, '0));
    random_phase(20);
    wait_drained();

    if (errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/stq_pkg.sv
rtl/core/stq_datapath.sv
rtl/core/stq_ctrl.sv
rtl/core/sorted_timer_queue.sv
verif/tb_sorted_timer_queue.sv
